/* hw/rtl/nnsa_pkg.sv */
// Shared types and constants for the nearest-neighbour scale address generator.
package nnsa_pkg;

  localparam int unsigned NNSA_MAX_DIM_DEF = 4096;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned AXES     = 2;
  localparam int unsigned AXIS_COL = 0;
  localparam int unsigned AXIS_ROW = 1;

  localparam int unsigned STEP_BITS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] dst_row;
    logic [COORD_W-1:0] dst_col;
  } nnsa_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
  } nnsa_out_t;

endpackage

/* hw/rtl/nearest_neighbor_scale_address.sv */
// Pipeline: one multiply stage, a restoring divider retiring STEP_BITS quotient bits per stage,
// and a clamp/output register.
// Throughput: one word per cycle; a stalled output holds every stage in place.
// Reset (synchronous, active low): clears all valid bits and sets every size to one.
// Nearest-neighbour scale address generator: pipelined top level.
module nearest_neighbor_scale_address
  import nnsa_pkg::*;
#(
  parameter int unsigned MAX_DIM = NNSA_MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nnsa_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nnsa_out_t            out_data
);

  localparam int unsigned LAST_W     = $clog2(MAX_DIM);
  localparam int unsigned DEN_W      = LAST_W + 1;
  localparam int unsigned PROD_W     = COORD_W + LAST_W;
  localparam int unsigned NUM_W      = PROD_W + 1;
  localparam int unsigned DIV_STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned QUO_W      = DIV_STAGES * STEP_BITS;

  function automatic logic [LAST_W-1:0] eff_last(input logic [SIZE_W-1:0] sz);
    int unsigned v;
    v = 32'(sz);
    if (v == 0) v = 1;
    if (v > MAX_DIM) v = MAX_DIM;
    return LAST_W'(v - 1);
  endfunction

  logic [LAST_W-1:0] src_last_r [AXES];
  logic [LAST_W-1:0] dst_last_r [AXES];

  logic [DEN_W-1:0]  den  [AXES];
  logic [LAST_W-1:0] lim  [AXES];

  logic [DIV_STAGES:0] vld_r;
  logic [QUO_W-1:0]    num_r   [DIV_STAGES+1][AXES];
  logic [QUO_W-1:0]    num_nxt [DIV_STAGES+1][AXES];
  logic [DEN_W-1:0]    rem_r   [DIV_STAGES+1][AXES];
  logic [DEN_W-1:0]    rem_nxt [DIV_STAGES+1][AXES];
  logic [QUO_W-1:0]    quo_r   [DIV_STAGES+1][AXES];
  logic [QUO_W-1:0]    quo_nxt [DIV_STAGES+1][AXES];

  logic      out_valid_r;
  nnsa_out_t out_data_r;
  nnsa_out_t out_data_nxt;

  logic advance;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        src_last_r[a] <= '0;
        dst_last_r[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SRC_WIDTH:  src_last_r[AXIS_COL] <= eff_last(cfg_wdata);
        REG_SRC_HEIGHT: src_last_r[AXIS_ROW] <= eff_last(cfg_wdata);
        REG_DST_WIDTH:  dst_last_r[AXIS_COL] <= eff_last(cfg_wdata);
        REG_DST_HEIGHT: dst_last_r[AXIS_ROW] <= eff_last(cfg_wdata);
      endcase
    end
  end

  // destination size one: clamp limit of zero forces the result to zero
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      den[a] = {dst_last_r[a], 1'b0};
      lim[a] = (dst_last_r[a] == '0) ? '0 : src_last_r[a];
    end
  end

  always_comb begin
    logic [COORD_W-1:0] coord;
    logic [PROD_W-1:0]  prod;
    logic [DEN_W-1:0]   r;
    logic [QUO_W-1:0]   n;
    logic [QUO_W-1:0]   q;
    logic [DEN_W:0]     trial;
    for (int a = 0; a < AXES; a++) begin
      coord = (a == AXIS_COL) ? in_data.dst_col : in_data.dst_row;
      prod  = PROD_W'(coord) * PROD_W'(src_last_r[a]);
      num_nxt[0][a] = QUO_W'({prod, 1'b0}) + QUO_W'(dst_last_r[a]);
      rem_nxt[0][a] = '0;
      quo_nxt[0][a] = '0;
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int a = 0; a < AXES; a++) begin
        r = rem_r[s][a];
        n = num_r[s][a];
        q = quo_r[s][a];
        for (int b = 0; b < STEP_BITS; b++) begin
          trial = {r, n[QUO_W-1]};
          n     = {n[QUO_W-2:0], 1'b0};
          if (trial >= {1'b0, den[a]}) begin
            r = DEN_W'(trial - {1'b0, den[a]});
            q = {q[QUO_W-2:0], 1'b1};
          end else begin
            r = trial[DEN_W-1:0];
            q = {q[QUO_W-2:0], 1'b0};
          end
        end
        num_nxt[s+1][a] = n;
        rem_nxt[s+1][a] = r;
        quo_nxt[s+1][a] = q;
      end
    end
  end

  always_comb begin
    logic [QUO_W-1:0] res [AXES];
    for (int a = 0; a < AXES; a++) begin
      if (quo_r[DIV_STAGES][a] > QUO_W'(lim[a])) begin
        res[a] = QUO_W'(lim[a]);
      end else begin
        res[a] = quo_r[DIV_STAGES][a];
      end
    end
    out_data_nxt.src_col = COORD_W'(res[AXIS_COL]);
    out_data_nxt.src_row = COORD_W'(res[AXIS_ROW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      vld_r       <= {vld_r[DIV_STAGES-1:0], in_valid};
      out_valid_r <= vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        for (int a = 0; a < AXES; a++) begin
          num_r[s][a] <= num_nxt[s][a];
          rem_r[s][a] <= rem_nxt[s][a];
          quo_r[s][a] <= quo_nxt[s][a];
        end
      end
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* sim/tb_nearest_neighbor_scale_address.sv */
// Self-checking testbench for the nearest-neighbour scale address generator.
module tb_nearest_neighbor_scale_address;
  import nnsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY   = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 150;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SIZE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  nnsa_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  nnsa_out_t            out_data;

  logic [SIZE_W-1:0] size_reg [4];
  nnsa_out_t         pending_src_coords [$];
  int                mismatch_count;
  int                quiet_cycles;
  int unsigned       burst_left;
  int unsigned       stall_left;
  int unsigned       stall_mode;

  nearest_neighbor_scale_address u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned effective_size(input logic [SIZE_W-1:0] r);
    if (r == 0) return 64'd1;
    if (r > NNSA_MAX_DIM_DEF) return 64'(NNSA_MAX_DIM_DEF);
    return 64'(r);
  endfunction

  function automatic logic [COORD_W-1:0] nearest_src(input logic [COORD_W-1:0] d,
                                                     input logic [SIZE_W-1:0] s_reg,
                                                     input logic [SIZE_W-1:0] d_reg);
    longint unsigned dd;
    longint unsigned s_last;
    longint unsigned d_last;
    longint unsigned q;
    dd     = 64'(d);
    s_last = effective_size(s_reg) - 1;
    d_last = effective_size(d_reg) - 1;
    if (d_last == 0) return '0;
    q = (2 * dd * s_last + d_last) / (2 * d_last);
    if (q > s_last) q = s_last;
    return q[COORD_W-1:0];
  endfunction

  function automatic nnsa_out_t predict_src_coord(input nnsa_in_t w);
    nnsa_out_t r;
    r.src_col = nearest_src(w.dst_col, size_reg[REG_SRC_WIDTH], size_reg[REG_DST_WIDTH]);
    r.src_row = nearest_src(w.dst_row, size_reg[REG_SRC_HEIGHT], size_reg[REG_DST_HEIGHT]);
    return r;
  endfunction

  // Mostly coordinates inside the destination, some at its last pixel, some anywhere.
  function automatic logic [COORD_W-1:0] rand_coord(input logic [SIZE_W-1:0] d_reg);
    int unsigned pick;
    int unsigned lim;
    pick = $urandom_range(0, 99);
    lim  = 32'(effective_size(d_reg));
    if (pick < 80) return COORD_W'($urandom_range(0, lim - 1));
    if (pick < 88) return COORD_W'(lim - 1);
    return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 2;
      2: return SIZE_W'(NNSA_MAX_DIM_DEF);
      3: return 0;
      4: return SIZE_W'($urandom_range(NNSA_MAX_DIM_DEF + 1, (1 << SIZE_W) - 1));
      5, 6: return SIZE_W'($urandom_range(1, 16));
      default: return SIZE_W'($urandom_range(1, NNSA_MAX_DIM_DEF));
    endcase
  endfunction

  // Called just after a rising edge; leaves in_valid high for the next word.
  task automatic send_coord(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    nnsa_in_t    w;
    int unsigned gap;
    w.dst_col = col;
    w.dst_row = row;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_src_coords.push_back(predict_src_coord(w));
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_src_coords.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    size_reg[idx] = v;
  endtask

  task automatic set_sizes(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                           input logic [SIZE_W-1:0] dw, input logic [SIZE_W-1:0] dh);
    drain_and_settle();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_sizes();
    send_coord(0, 0);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'hAAA, 12'h555);
    send_coord(12'h555, 12'hAAA);
  endtask

  task automatic test_corner_alignment();
    set_sizes(640, 480, 1280, 960);
    send_coord(0, 0);
    send_coord(1279, 959);
    send_coord(1, 1);
    send_coord(640, 480);
    send_coord(639, 479);
  endtask

  task automatic test_unit_destination();
    set_sizes(4096, 4096, 1, 1);
    send_coord(0, 0);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(2048, 7);
  endtask

  task automatic test_zero_size();
    set_sizes(0, 0, 0, 0);
    send_coord(0, 0);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(100, 200);
  endtask

  task automatic test_oversize();
    set_sizes(13'h1FFF, 5000, 13'h1FFF, 4097);
    send_coord(0, 0);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(2047, 2048);
    send_coord(1, 4094);
  endtask

  task automatic test_beyond_destination();
    set_sizes(4096, 4096, 2, 100);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(2, 100);
    send_coord(1, 99);
    send_coord(3000, 50);
  endtask

  task automatic test_random_sizes();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_sizes(rand_size(), rand_size(), rand_size(), rand_size());
      repeat (PHASE_WORDS)
        send_coord(rand_coord(size_reg[REG_DST_WIDTH]), rand_coord(size_reg[REG_DST_HEIGHT]));
    end
  endtask

  // Receiver: hold ready, stall at random, mostly ready or mostly stall, in stretches of random length.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    nnsa_out_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_src_coords.size() == 0) begin
        $error("unexpected result word: src_col %0d src_row %0d",
               out_data.src_col, out_data.src_row);
        mismatch_count++;
      end else begin
        exp_word = pending_src_coords.pop_front();
        if (out_data.src_col !== exp_word.src_col) begin
          $error("src_col: expected %0d, got %0d", exp_word.src_col, out_data.src_col);
          mismatch_count++;
        end
        if (out_data.src_row !== exp_word.src_row) begin
          $error("src_row: expected %0d, got %0d", exp_word.src_row, out_data.src_row);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    burst_left     = 0;
    stall_left     = 0;
    stall_mode     = 0;
    size_reg[REG_SRC_WIDTH]  = 1;
    size_reg[REG_SRC_HEIGHT] = 1;
    size_reg[REG_DST_WIDTH]  = 1;
    size_reg[REG_DST_HEIGHT] = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_sizes();
    test_corner_alignment();
    test_unit_destination();
    test_zero_size();
    test_oversize();
    test_beyond_destination();
    test_random_sizes();

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
